@@ hdl/pnhl_pkg.sv @@
// Package: shared types and constants for the per-pixel k-buffer.
package pnhl_pkg;

    localparam int PIXELS    = 1024;
    localparam int LAYERS    = 8;
    localparam int PIX_W     = $clog2(PIXELS);
    localparam int LAY_W     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int ML_W      = $clog2(LAYERS + 1);
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_LAYERS    = 2'd0;
    localparam logic [1:0] CFG_REGION_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_REGION_HEIGHT = 2'd2;

    // input item
    typedef struct packed {
        logic        mode;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [63:0] user_data;
        logic [31:0] depth_key;
    } in_item_t;

    // result item
    typedef struct packed {
        logic        hit_valid;
        logic [63:0] hit_user_data;
        logic [31:0] hit_depth;
        logic [2:0]  layer_index;
        logic        last;
        logic        overflowed;
        logic [15:0] hit_count;
    } out_item_t;

    // one kept hit
    typedef struct packed {
        logic [63:0] data;
        logic [31:0] depth;
    } hit_t;

    // per-cell control from the top level
    typedef struct packed {
        logic             load;   // load the row from memory words
        logic             ins;    // insertion step
        logic             shift;  // readback shift toward cell 0
        logic [ML_W-1:0]  kept;   // hits kept before this insert
    } cell_ctl_t;

endpackage

@@ hdl/per_pixel_nearest_hit_layers_unit.sv @@
// Per-pixel k-buffer: top level with pixel stores and sequencer.
// Insert: address, memory read, cell compare, write back, then back to idle.
// Read: address, memory read, then one result per cycle; done after the last.
// A new item is taken only in idle, once the last one is done; busy is high until then.
// Results cannot be stalled. Layer store is undefined until written.
// After reset a clearing pass zeroes the hit counts of all pixels; busy is high then.
module per_pixel_nearest_hit_layers_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pnhl_pkg::in_item_t   in_item,
    output logic                 result_strobe,
    output pnhl_pkg::out_item_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [10:0]          cfg_data
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  max_layers_reg;
    logic [10:0] width_reg, height_reg;
    pnhl_pkg::in_item_t item_reg;
    logic [pnhl_pkg::PIX_W-1:0] pix_reg;
    logic        inside_reg;
    logic [pnhl_pkg::PIX_W:0] clr_reg;
    logic [15:0] count_reg;
    logic [pnhl_pkg::ML_W-1:0] kept_reg, ml_reg, out_idx_reg;
    logic        ovf_reg;
    logic        strobe_reg;
    pnhl_pkg::out_item_t result_reg;
    pnhl_pkg::out_item_t result_next;

    // memories
    logic [15:0]          cnt_mem [pnhl_pkg::PIXELS];
    pnhl_pkg::hit_t       rd_hits [pnhl_pkg::LAYERS];
    pnhl_pkg::hit_t       hits    [pnhl_pkg::LAYERS];
    logic [15:0]          cnt_rd;

    pnhl_pkg::cell_ctl_t ctl;
    pnhl_pkg::hit_t      new_hit;

    logic [21:0] paddr;
    logic        in_range;
    logic [pnhl_pkg::ML_W-1:0] ml_eff;
    logic [pnhl_pkg::ML_W-1:0] kept_c;
    logic        ovf_c;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // pixel address from the latched item
    assign paddr    = 22'(item_reg.pixel_y) * 22'(width_reg) + 22'(item_reg.pixel_x);
    assign in_range = ({1'b0, item_reg.pixel_x} < width_reg)
                      && ({1'b0, item_reg.pixel_y} < height_reg)
                      && (paddr < 22'(pnhl_pkg::PIXELS));

    assign ml_eff = (max_layers_reg > 4'(pnhl_pkg::LAYERS)) ?
                    pnhl_pkg::ML_W'(pnhl_pkg::LAYERS) : pnhl_pkg::ML_W'(max_layers_reg);
    assign kept_c = (cnt_rd < 16'(ml_reg)) ? pnhl_pkg::ML_W'(cnt_rd) : ml_reg;
    assign ovf_c  = (cnt_rd > 16'(ml_reg));

    assign new_hit.data  = item_reg.user_data;
    assign new_hit.depth = item_reg.depth_key;

    // cell controls; a full row makes the last slot the insert end if nearer
    always_comb
    begin
        ctl.load  = (state_reg == S_RD);
        ctl.ins   = (state_reg == S_INS) && inside_reg && (ml_reg != '0)
                    && !(kept_reg == ml_reg
                         && item_reg.depth_key
                            >= hits[pnhl_pkg::LAY_W'(kept_reg - 1'b1)].depth);
        ctl.shift = (state_reg == S_OUT);
        ctl.kept  = (kept_reg == ml_reg && ml_reg != '0) ? kept_reg - 1'b1 : kept_reg;
    end

    pnhl_chain u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .load_hits (rd_hits),
        .new_hit   (new_hit),
        .hits      (hits)
    );

    // memory ports
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            cnt_mem[clr_reg[pnhl_pkg::PIX_W-1:0]] <= '0;
        else if (state_reg == S_INS && inside_reg && cnt_rd != pnhl_pkg::COUNT_MAX)
            cnt_mem[pix_reg] <= cnt_rd + 16'd1;
        if (state_reg == S_ADDR)
            cnt_rd <= cnt_mem[in_range ? paddr[pnhl_pkg::PIX_W-1:0] : '0];
    end

    // one layer bank per slot position
    for (genvar l = 0; l < pnhl_pkg::LAYERS; l++)
    begin : g_mem
        pnhl_pkg::hit_t bank [pnhl_pkg::PIXELS];
        pnhl_pkg::hit_t rd_word_reg;

        always_ff @(posedge clk)
        begin
            if (state_reg == S_WB && inside_reg)
                bank[pix_reg] <= hits[l];
            if (state_reg == S_ADDR)
                rd_word_reg <= bank[in_range ? paddr[pnhl_pkg::PIX_W-1:0] : '0];
        end

        assign rd_hits[l] = rd_word_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (pnhl_pkg::PIX_W+1)'(pnhl_pkg::PIXELS - 1))
                         state_next = S_IDLE;
            S_IDLE:  if (start) state_next = S_ADDR;
            S_ADDR:  state_next = S_RD;
            S_RD:    state_next = item_reg.mode ? S_OUT : S_INS;
            S_INS:   state_next = S_WB;
            S_WB:    state_next = S_IDLE;
            S_OUT:   if (!inside_reg || kept_reg == '0 || out_idx_reg + 1'b1 >= kept_reg)
                         state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            max_layers_reg <= 4'd8;
            width_reg      <= 11'd32;
            height_reg     <= 11'd32;
            strobe_reg     <= 1'b0;
            out_idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_OUT);
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pnhl_pkg::CFG_MAX_LAYERS:    max_layers_reg <= cfg_data[3:0];
                    pnhl_pkg::CFG_REGION_WIDTH:  width_reg      <= cfg_data;
                    pnhl_pkg::CFG_REGION_HEIGHT: height_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_RD)
                out_idx_reg <= '0;
            else if (state_reg == S_OUT)
                out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    // next result: invalid single result unless a kept hit is at cell 0
    always_comb
    begin
        result_next      = '0;
        result_next.last = 1'b1;
        if (inside_reg)
        begin
            result_next.overflowed = ovf_reg;
            result_next.hit_count  = count_reg;
            if (kept_reg != '0)
            begin
                result_next.hit_valid     = 1'b1;
                result_next.hit_user_data = hits[0].data;
                result_next.hit_depth     = hits[0].depth;
                result_next.layer_index   = 3'(out_idx_reg);
                result_next.last          = (out_idx_reg + 1'b1 >= kept_reg);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            item_reg <= in_item;
        if (state_reg == S_ADDR)
        begin
            pix_reg    <= paddr[pnhl_pkg::PIX_W-1:0];
            inside_reg <= in_range;
            ml_reg     <= ml_eff;
        end
        if (state_reg == S_RD)
        begin
            count_reg <= cnt_rd;
            kept_reg  <= kept_c;
            ovf_reg   <= ovf_c;
        end
        if (state_reg == S_OUT)
            result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;
endmodule

@@ hdl/pnhl_cell.sv @@
// One k-buffer cell: holds one layer slot and compares/shifts with its neighbor.
module pnhl_cell (
    input  logic               clk,
    input  pnhl_pkg::cell_ctl_t ctl,
    input  logic [pnhl_pkg::LAY_W-1:0] idx,
    input  pnhl_pkg::hit_t     load_hit,
    input  pnhl_pkg::hit_t     new_hit,
    input  pnhl_pkg::hit_t     left_hit,
    input  logic               left_moves,
    input  pnhl_pkg::hit_t     right_hit,
    output pnhl_pkg::hit_t     hit,
    output logic               moves
);
    pnhl_pkg::hit_t hit_reg;
    pnhl_pkg::hit_t hit_next;
    logic           occupied;
    logic           farther;
    logic           at_end;

    // slot holds a kept hit; new hit goes before it if strictly nearer
    assign occupied = (pnhl_pkg::ML_W'(idx) < ctl.kept);
    assign at_end   = ({{(pnhl_pkg::ML_W-pnhl_pkg::LAY_W){1'b0}}, idx} == ctl.kept);
    assign farther  = occupied && !at_end && (hit_reg.depth > new_hit.depth);
    assign moves    = farther;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.load)
            hit_next = load_hit;
        else if (ctl.shift)
            hit_next = right_hit;
        else if (ctl.ins)
        begin
            if (left_moves)
                hit_next = left_hit;
            else if (farther || at_end)
                hit_next = new_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit = hit_reg;
endmodule

@@ hdl/pnhl_chain.sv @@
// Row of k-buffer cells for one pixel.
module pnhl_chain (
    input  logic                clk,
    input  pnhl_pkg::cell_ctl_t ctl,
    input  pnhl_pkg::hit_t      load_hits [pnhl_pkg::LAYERS],
    input  pnhl_pkg::hit_t      new_hit,
    output pnhl_pkg::hit_t      hits      [pnhl_pkg::LAYERS]
);
    logic mv [pnhl_pkg::LAYERS];

    for (genvar i = 0; i < pnhl_pkg::LAYERS; i++)
    begin : g_cell
        pnhl_pkg::hit_t lh;
        pnhl_pkg::hit_t rh;
        logic           lm;
        if (i == 0)
        begin : g_first
            assign lh = new_hit;
            assign lm = 1'b0;
        end
        else
        begin : g_mid
            assign lh = hits[i-1];
            assign lm = mv[i-1];
        end
        if (i == pnhl_pkg::LAYERS - 1)
        begin : g_last
            assign rh = hits[i];
        end
        else
        begin : g_rest
            assign rh = hits[i+1];
        end
        pnhl_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (pnhl_pkg::LAY_W'(i)),
            .load_hit   (load_hits[i]),
            .new_hit    (new_hit),
            .left_hit   (lh),
            .left_moves (lm),
            .right_hit  (rh),
            .hit        (hits[i]),
            .moves      (mv[i])
        );
    end
endmodule
